### hw/rtl/timing_offset_histogram_peak_macros.svh
// assertion macros shared by the timing offset histogram rtl
// expects clk and arst_n to be visible in the module that uses them
`ifndef TIMING_OFFSET_HISTOGRAM_PEAK_MACROS_SVH
`define TIMING_OFFSET_HISTOGRAM_PEAK_MACROS_SVH

// same-cycle implication, checked outside reset
`define TOHP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TOHP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tohp_pkg.sv
// shared constants, types and helpers for the timing offset histogram
// no dependencies
`default_nettype none

package tohp_pkg;

	// sizing
	localparam int NUM_SOURCES = 8;
	localparam int NUM_MODULES = 14;
	localparam int NUM_BINS    = 128;
	localparam int COUNT_WIDTH = 32;

	localparam int SOURCE_BASE = 3001;
	localparam logic [6:0] OFFSET_MASK = 7'h7F;

	localparam int DEPTH  = NUM_SOURCES * NUM_MODULES * NUM_BINS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int MOD_W  = 4;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HIT_WR,
		ST_SCAN,
		ST_WAIT,
		ST_BELOW,
		ST_ABOVE,
		ST_EMIT
	} state_t;

	// memory address source
	typedef enum logic [2:0] {
		ADDR_INPUT,
		ADDR_HIT,
		ADDR_SCAN,
		ADDR_BELOW,
		ADDR_ABOVE,
		ADDR_CLEAR
	} addr_sel_t;

	typedef struct packed {
		logic      capture;
		addr_sel_t addr_sel;
		logic      wr_incr;
		logic      wr_clear;
		logic      clr_step;
		logic      scan_rd;
		logic      mod_next;
		logic      below_ld;
		logic      emit;
	} cmd_t;

	typedef struct packed {
		logic item_ok;
		logic item_query;
		logic bin_last;
		logic mod_last;
		logic clr_last;
	} status_t;

	// flat counter address of (source, module, bin)
	function automatic logic [ADDR_W-1:0] hist_addr(
		input logic [SRC_W-1:0] src,
		input logic [MOD_W-1:0] mod,
		input logic [BIN_W-1:0] bin
	);
		return ADDR_W'((int'(src) * NUM_MODULES + int'(mod)) * NUM_BINS + int'(bin));
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tohp_ctrl.sv
// controller state machine: clearing pass, hit update and peak query walk
// depends on tohp_pkg and timing_offset_histogram_peak_macros.svh
`default_nettype none
`include "timing_offset_histogram_peak_macros.svh"

module tohp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire tohp_pkg::status_t sts,
	output tohp_pkg::cmd_t         cmd
);
	import tohp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && sts.item_ok) begin
					state_nxt = sts.item_query ? ST_SCAN : ST_HIT_WR;
				end
			end
			ST_HIT_WR: state_nxt = ST_IDLE;
			ST_SCAN: begin
				if (sts.bin_last) state_nxt = ST_WAIT;
			end
			ST_WAIT:  state_nxt = ST_BELOW;
			ST_BELOW: state_nxt = ST_ABOVE;
			ST_ABOVE: state_nxt = ST_EMIT;
			ST_EMIT: begin
				state_nxt = sts.mod_last ? ST_IDLE : ST_SCAN;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.addr_sel = ADDR_INPUT;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.addr_sel = ADDR_CLEAR;
				cmd.wr_clear = 1'b1;
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				cmd.addr_sel = ADDR_INPUT;
				cmd.capture  = start;
			end
			ST_HIT_WR: begin
				cmd.addr_sel = ADDR_HIT;
				cmd.wr_incr  = 1'b1;
			end
			ST_SCAN: begin
				cmd.addr_sel = ADDR_SCAN;
				cmd.scan_rd  = 1'b1;
			end
			ST_WAIT: begin
				cmd.addr_sel = ADDR_SCAN;
			end
			ST_BELOW: begin
				cmd.addr_sel = ADDR_BELOW;
			end
			ST_ABOVE: begin
				cmd.addr_sel = ADDR_ABOVE;
				cmd.below_ld = 1'b1;
			end
			ST_EMIT: begin
				cmd.addr_sel = ADDR_SCAN;
				cmd.emit     = 1'b1;
				cmd.mod_next = 1'b1;
			end
			default: begin
				cmd.addr_sel = ADDR_INPUT;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`TOHP_ASSERT_NXT(a_hit_one_write, state_q == ST_HIT_WR, state_q == ST_IDLE, "hit update longer than one cycle")
	`TOHP_ASSERT_NXT(a_next_module, (state_q == ST_EMIT) && !sts.mod_last, state_q == ST_SCAN, "query stopped before last module")
	`TOHP_ASSERT_NXT(a_clear_runs, (state_q == ST_CLEAR) && !sts.clr_last, state_q == ST_CLEAR, "clearing pass cut short")

endmodule

`default_nettype wire

### hw/rtl/tohp_datapath.sv
// datapath: item decode, histogram memory, peak compare and result registers
// depends on tohp_pkg and timing_offset_histogram_peak_macros.svh
`default_nettype none
`include "timing_offset_histogram_peak_macros.svh"

module tohp_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              mode,
	input  wire logic [11:0]       source_id,
	input  wire logic [3:0]        module_index,
	input  wire logic [6:0]        hit_counter,
	input  wire logic [2:0]        hit_adc,
	input  wire logic [6:0]        clock_low,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire tohp_pkg::cmd_t    cmd,
	output tohp_pkg::status_t      sts,
	output logic [3:0]             result_module,
	output logic [6:0]             peak_offset,
	output logic [31:0]            peak_count,
	output logic [31:0]            below_count,
	output logic [31:0]            above_count,
	output logic                   last,
	output logic                   done
);
	import tohp_pkg::*;

	logic                   adc_cut_enable_q;
	logic                   src_ok;
	logic [SRC_W-1:0]       in_src;
	logic [6:0]             in_offset;
	logic                   hit_ok;
	logic [ADDR_W-1:0]      in_addr;
	logic [SRC_W-1:0]       src_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [MOD_W-1:0]       mod_q;
	logic [BIN_W-1:0]       bin_q;
	logic [ADDR_W-1:0]      clr_q;
	logic                   scan_rd_s1;
	logic [BIN_W-1:0]       bin_s1;
	logic [BIN_W-1:0]       best_bin_q;
	logic [COUNT_WIDTH-1:0] best_cnt_q;
	logic [COUNT_WIDTH-1:0] below_q;
	logic [BIN_W-1:0]       below_bin;
	logic [BIN_W-1:0]       above_bin;
	logic [ADDR_W-1:0]      mem_addr;
	logic                   mem_we;
	logic [COUNT_WIDTH-1:0] mem_wdata;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [COUNT_WIDTH-1:0] hist_mem [DEPTH];
	logic [3:0]             res_module_q;
	logic [6:0]             res_offset_q;
	logic [COUNT_WIDTH-1:0] res_peak_q;
	logic [COUNT_WIDTH-1:0] res_below_q;
	logic [COUNT_WIDTH-1:0] res_above_q;
	logic                   res_last_q;
	logic                   done_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_cut_enable_q <= 1'b0;
		end else if (cfg_we) begin
			adc_cut_enable_q <= cfg_wdata;
		end
	end

	// item decode
	assign src_ok    = (source_id >= 12'(SOURCE_BASE))
		&& (source_id < 12'(SOURCE_BASE + NUM_SOURCES));
	assign in_src    = SRC_W'(source_id - 12'(SOURCE_BASE));
	assign in_offset = (clock_low - hit_counter) & OFFSET_MASK;
	assign hit_ok    = !((hit_adc == 3'd0) && adc_cut_enable_q)
		&& ({1'b0, module_index} < 5'(NUM_MODULES))
		&& ({1'b0, in_offset} < 8'(NUM_BINS));
	assign in_addr   = hist_addr(in_src, module_index, in_offset[BIN_W-1:0]);

	assign sts.item_ok    = src_ok && (mode || hit_ok);
	assign sts.item_query = mode;
	assign sts.bin_last   = (bin_q == BIN_W'(NUM_BINS - 1));
	assign sts.mod_last   = (mod_q == MOD_W'(NUM_MODULES - 1));
	assign sts.clr_last   = (clr_q == ADDR_W'(DEPTH - 1));

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q  <= in_src;
			addr_q <= in_addr;
		end
	end

	// module, bin and clear counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q      <= '0;
			bin_q      <= '0;
			clr_q      <= '0;
			scan_rd_s1 <= 1'b0;
		end else begin
			if (cmd.capture) begin
				mod_q <= '0;
			end else if (cmd.mod_next) begin
				mod_q <= mod_q + MOD_W'(1);
			end
			if (cmd.capture) begin
				bin_q <= '0;
			end else if (cmd.scan_rd) begin
				bin_q <= sts.bin_last ? '0 : bin_q + BIN_W'(1);
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			scan_rd_s1 <= cmd.scan_rd;
		end
	end

	// running maximum, first bin wins on ties
	always_ff @(posedge clk) begin
		bin_s1 <= bin_q;
		if (scan_rd_s1) begin
			if ((bin_s1 == '0) || (rd_data_q > best_cnt_q)) begin
				best_cnt_q <= rd_data_q;
				best_bin_q <= bin_s1;
			end
		end
		if (cmd.below_ld) begin
			below_q <= rd_data_q;
		end
	end

	// circular neighbours of the peak
	assign below_bin = (best_bin_q == '0) ? BIN_W'(NUM_BINS - 1) : best_bin_q - BIN_W'(1);
	assign above_bin = (best_bin_q == BIN_W'(NUM_BINS - 1)) ? '0 : best_bin_q + BIN_W'(1);

	// memory address select
	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_INPUT: mem_addr = in_addr;
			ADDR_HIT:   mem_addr = addr_q;
			ADDR_SCAN:  mem_addr = hist_addr(src_q, mod_q, bin_q);
			ADDR_BELOW: mem_addr = hist_addr(src_q, mod_q, below_bin);
			ADDR_ABOVE: mem_addr = hist_addr(src_q, mod_q, above_bin);
			ADDR_CLEAR: mem_addr = clr_q;
			default:    mem_addr = in_addr;
		endcase
	end

	// saturating increment or clear
	assign mem_we    = cmd.wr_incr || cmd.wr_clear;
	assign mem_wdata = cmd.wr_clear ? '0
		: ((rd_data_q == CNT_MAX) ? rd_data_q : rd_data_q + COUNT_WIDTH'(1));

	// histogram memory, single port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_addr] <= mem_wdata;
		end
		rd_data_q <= hist_mem[mem_addr];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_module_q <= mod_q;
			res_offset_q <= 7'(best_bin_q);
			res_peak_q   <= best_cnt_q;
			res_below_q  <= below_q;
			res_above_q  <= rd_data_q;
			res_last_q   <= sts.mod_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign result_module = res_module_q;
	assign peak_offset   = res_offset_q;
	assign peak_count    = 32'(res_peak_q);
	assign below_count   = 32'(res_below_q);
	assign above_count   = 32'(res_above_q);
	assign last          = res_last_q;
	assign done          = done_q;

	`TOHP_ASSERT_IMP(a_done_after_emit, done_q, $past(cmd.emit), "result strobe without emit")
	`TOHP_ASSERT_NXT(a_first_bin_loads, scan_rd_s1 && (bin_s1 == '0), best_bin_q == '0, "scan did not restart at bin zero")
	`TOHP_ASSERT_IMP(a_no_write_in_scan, cmd.scan_rd, !mem_we, "histogram write during peak scan")

endmodule

`default_nettype wire

### hw/rtl/timing_offset_histogram_peak.sv
// timing offset histogram with per-module peak finder, top level
// hit: counter read in the accept cycle, written back in ST_HIT_WR with busy high
// dropped item: not taken, busy stays low; query: per module a scan of its 128 bins, then
// ST_WAIT, ST_BELOW, ST_ABOVE, ST_EMIT; busy through all 14; results cannot be held off
// reset: adc cut off, a clearing pass zeroes all 14336 counters, busy high until it ends
// depends on tohp_pkg, tohp_ctrl and tohp_datapath
`default_nettype none

module timing_offset_histogram_peak (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [11:0] source_id,
	input  wire logic [3:0]  module_index,
	input  wire logic [6:0]  hit_counter,
	input  wire logic [2:0]  hit_adc,
	input  wire logic [6:0]  clock_low,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	output logic             done,
	output logic [3:0]       result_module,
	output logic [6:0]       peak_offset,
	output logic [31:0]      peak_count,
	output logic [31:0]      below_count,
	output logic [31:0]      above_count,
	output logic             last
);
	import tohp_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// controller
	tohp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath
	tohp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.source_id     (source_id),
		.module_index  (module_index),
		.hit_counter   (hit_counter),
		.hit_adc       (hit_adc),
		.clock_low     (clock_low),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.result_module (result_module),
		.peak_offset   (peak_offset),
		.peak_count    (peak_count),
		.below_count   (below_count),
		.above_count   (above_count),
		.last          (last),
		.done          (done)
	);

endmodule

`default_nettype wire
